// ----- sv/lmlt_pkg.sv -----
// shared types and constants for the lcd mode and line timing block
package lmlt_pkg;

	// line timing constants
	localparam int unsigned CLOCK_W = 10;
	localparam logic [CLOCK_W-1:0] LINE_CYCLES = 10'd456;
	localparam logic [CLOCK_W-1:0] OAM_END     = 10'd80;
	localparam logic [CLOCK_W-1:0] XFER_END    = 10'd252;
	localparam logic [7:0]         VBLANK_LINE = 8'd144;
	localparam logic [7:0]         LAST_LINE   = 8'd153;

	// status mode codes
	typedef enum logic [1:0] {
		MODE_HBLANK = 2'd0,
		MODE_VBLANK = 2'd1,
		MODE_OAM    = 2'd2,
		MODE_XFER   = 2'd3
	} lcd_mode_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_DISPLAY_ENABLE    = 3'd0,
		REG_BACKGROUND_ENABLE = 3'd1,
		REG_SPRITE_ENABLE     = 3'd2,
		REG_HBLANK_IRQ_EN     = 3'd3,
		REG_VBLANK_STAT_IRQ_EN = 3'd4,
		REG_OAM_IRQ_EN        = 3'd5,
		REG_MATCH_IRQ_EN      = 3'd6,
		REG_LINE_COMPARE      = 3'd7
	} cfg_index_t;

	// configuration register contents
	typedef struct packed {
		logic       display_enable;
		logic       background_enable;
		logic       sprite_enable;
		logic       hblank_irq_enable;
		logic       vblank_stat_irq_enable;
		logic       oam_irq_enable;
		logic       match_irq_enable;
		logic [7:0] line_compare;
	} cfg_t;

	// one result beat
	typedef struct packed {
		lcd_mode_t  mode;
		logic [7:0] line;
		logic       coincidence;
		logic       vblank_irq;
		logic       stat_irq;
		logic       draw_request;
		logic       draw_background;
		logic       draw_sprites;
	} result_t;

endpackage

// ----- sv/lmlt_cfg.sv -----
// configuration register file for the lcd timing block
module lmlt_cfg import lmlt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_en,
	input  logic [2:0] wr_index,
	input  logic [7:0] wr_data,
	output cfg_t       cfg
);

	cfg_t cfg_q;

	// register writes, reset to the power-on control values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q                        <= '0;
			cfg_q.display_enable         <= 1'b1;
			cfg_q.background_enable      <= 1'b1;
		end else if (wr_en) begin
			unique case (cfg_index_t'(wr_index))
				REG_DISPLAY_ENABLE:     cfg_q.display_enable         <= wr_data[0];
				REG_BACKGROUND_ENABLE:  cfg_q.background_enable      <= wr_data[0];
				REG_SPRITE_ENABLE:      cfg_q.sprite_enable          <= wr_data[0];
				REG_HBLANK_IRQ_EN:      cfg_q.hblank_irq_enable      <= wr_data[0];
				REG_VBLANK_STAT_IRQ_EN: cfg_q.vblank_stat_irq_enable <= wr_data[0];
				REG_OAM_IRQ_EN:         cfg_q.oam_irq_enable         <= wr_data[0];
				REG_MATCH_IRQ_EN:       cfg_q.match_irq_enable       <= wr_data[0];
				REG_LINE_COMPARE:       cfg_q.line_compare           <= wr_data;
				default:                cfg_q                        <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- sv/lmlt_timing.sv -----
// line clock, line counter and mode state with the per-beat step logic
module lmlt_timing import lmlt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] cycles,
	input  cfg_t       cfg,
	output result_t    res
);

	logic [CLOCK_W-1:0] clock_q, clock_d, clock_sum;
	logic [7:0]         line_q, line_d, line_inc;
	lcd_mode_t          mode_q, mode_d;
	logic               irq_en;
	logic               coin;

	// derive mode from pre-step state, then advance the line clock
	always_comb begin
		res       = '0;
		clock_d   = clock_q;
		line_d    = line_q;
		mode_d    = mode_q;
		irq_en    = 1'b0;
		coin      = 1'b0;
		clock_sum = clock_q + CLOCK_W'(cycles);
		line_inc  = line_q + 8'd1;
		if (!cfg.display_enable) begin
			clock_d  = '0;
			line_d   = '0;
			mode_d   = MODE_VBLANK;
			res.mode = MODE_VBLANK;
		end else begin
			if (line_q >= VBLANK_LINE) begin
				mode_d = MODE_VBLANK;
				irq_en = cfg.vblank_stat_irq_enable;
			end else if (clock_q <= OAM_END) begin
				mode_d = MODE_OAM;
				irq_en = cfg.oam_irq_enable;
			end else if (clock_q <= XFER_END) begin
				mode_d = MODE_XFER;
				irq_en = 1'b0;
			end else begin
				mode_d = MODE_HBLANK;
				irq_en = cfg.hblank_irq_enable;
			end
			coin         = (line_q == cfg.line_compare);
			res.mode     = mode_d;
			res.coincidence = coin;
			res.stat_irq = (irq_en && (mode_d != mode_q)) || (coin && cfg.match_irq_enable);
			// clock is cleared at end of line, excess dropped
			if (clock_sum >= LINE_CYCLES) begin
				clock_d = '0;
				if (line_inc == VBLANK_LINE) begin
					line_d         = line_inc;
					res.vblank_irq = 1'b1;
				end else if (line_inc > LAST_LINE) begin
					line_d           = '0;
					res.draw_request = 1'b1;
				end else begin
					line_d           = line_inc;
					res.draw_request = (line_inc < VBLANK_LINE);
				end
			end else begin
				clock_d = clock_sum;
			end
			res.draw_background = res.draw_request & cfg.background_enable;
			res.draw_sprites    = res.draw_request & cfg.sprite_enable;
		end
		res.line = line_d;
	end

	// state update once per processed beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q <= '0;
			line_q  <= '0;
			mode_q  <= MODE_HBLANK;
		end else if (step) begin
			clock_q <= clock_d;
			line_q  <= line_d;
			mode_q  <= mode_d;
		end
	end

endmodule

// ----- sv/lcd_mode_and_line_timing.sv -----
// top level of the lcd mode and line timing block
// a beat passes through the input register and then the result register
// throughput: one beat per cycle unless out_ready stalls the output; the input
// and result registers hold one beat each; the step logic between them sets the rate
// reset: arst_n clears line clock, line and mode to zero and loads the control
// register defaults (display and background on, everything else off)
module lcd_mode_and_line_timing import lmlt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] cycles,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] mode,
	output logic [7:0] line,
	output logic       coincidence,
	output logic       vblank_irq,
	output logic       stat_irq,
	output logic       draw_request,
	output logic       draw_background,
	output logic       draw_sprites
);

	cfg_t       cfg;
	result_t    res;
	result_t    result_s2;
	logic       valid_s1, valid_s2;
	logic [7:0] cycles_s1;
	logic       out_free;
	logic       advance;

	assign cfg_ready = 1'b1;

	lmlt_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// handshake between input register and result register
	assign out_free = !valid_s2 || out_ready;
	assign advance  = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	lmlt_timing u_timing (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.cycles (cycles_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cycles_s1 <= cycles;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= res;
		end
	end

	assign out_valid       = valid_s2;
	assign mode            = result_s2.mode;
	assign line            = result_s2.line;
	assign coincidence     = result_s2.coincidence;
	assign vblank_irq      = result_s2.vblank_irq;
	assign stat_irq        = result_s2.stat_irq;
	assign draw_request    = result_s2.draw_request;
	assign draw_background = result_s2.draw_background;
	assign draw_sprites    = result_s2.draw_sprites;

endmodule

// ----- sv/lmlt_checker.sv -----
// port-level checks for the lcd timing block, bound to the top level
module lmlt_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] mode,
	input logic [7:0] line,
	input logic       vblank_irq,
	input logic       draw_request,
	input logic       draw_background,
	input logic       draw_sprites
);

	// a stalled result beat keeps its line and mode
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(line) && $stable(mode))
		else $error("stalled result beat changed");

	// line never leaves the frame
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> line <= 8'd153)
		else $error("line out of range");

	// vblank only on arrival at line 144, never with a draw request
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && vblank_irq |-> line == 8'd144 && !draw_request)
		else $error("vblank irq on wrong line");

	// layer flags only travel with a draw request on a visible line
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (draw_background || draw_sprites) |-> draw_request && line < 8'd144)
		else $error("layer flags without draw request");

endmodule

bind lcd_mode_and_line_timing lmlt_checker u_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.mode            (mode),
	.line            (line),
	.vblank_irq      (vblank_irq),
	.draw_request    (draw_request),
	.draw_background (draw_background),
	.draw_sprites    (draw_sprites)
);
